// ===== src/rlftq_pkg.sv =====
package rlftq_pkg;

	// Item kinds carried in the input tuser
	typedef enum logic [1:0] {
		FUNC_PUSH = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_LEN = 2'd2,
		ST_NONE    = 2'd3
	} status_t;

	localparam logic [1:0] LINK_OK   = 2'd0;
	localparam logic [1:0] LINK_BUSY = 2'd1;

	// Bits of the latched push reject reasons
	localparam int REJ_FULL = 0;
	localparam int REJ_LONG = 1;

	localparam logic [15:0] SEND_INTERVAL_RESET = 16'd115;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	// Depth of the command queue between front and back
	localparam int CMD_Q_DEPTH = 2;

	typedef struct packed {
		func_t      func;
		logic [7:0] data_byte;
		logic       last_byte;
		logic       link_ready;
		logic [1:0] link_status;
		logic [6:0] byte_offset;
	} cmd_t;

	// Packed with status in the low bits
	typedef struct packed {
		logic [5:0] queue_count;
		logic [7:0] read_data;
		logic [7:0] frame_length;
		logic       dropped;
		logic       sent;
		status_t    status;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_LEN  = 2'd1,
		BK_READ = 2'd2
	} back_state_t;

endpackage

// ===== src/rlftq_front.sv =====
module rlftq_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [rlftq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic                                s_axis_tlast,
	input  logic [1:0]                          s_axis_tuser,
	output logic                                cmd_valid,
	input  logic                                cmd_ready,
	output rlftq_pkg::cmd_t                     cmd
);

	localparam int CNT_W = $clog2(rlftq_pkg::CMD_Q_DEPTH + 1);
	localparam int PTR_W = $clog2(rlftq_pkg::CMD_Q_DEPTH);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rlftq_pkg::CMD_Q_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rlftq_pkg::CMD_Q_DEPTH - 1);

	rlftq_pkg::cmd_t cmd_q [rlftq_pkg::CMD_Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	rlftq_pkg::cmd_t  in_cmd;
	logic             push;
	logic             pop;

	// Classify the incoming transfer into a command
	always_comb begin
		in_cmd.func        = rlftq_pkg::func_t'(s_axis_tuser);
		in_cmd.data_byte   = s_axis_tdata[7:0];
		in_cmd.last_byte   = s_axis_tlast;
		in_cmd.link_ready  = s_axis_tdata[8];
		in_cmd.link_status = s_axis_tdata[10:9];
		in_cmd.byte_offset = s_axis_tdata[17:11];
	end

	assign s_axis_tready = (cnt_q != FULL_CNT);
	assign cmd_valid     = (cnt_q != '0);
	assign cmd           = cmd_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/rlftq_back.sv =====
module rlftq_back #(
	parameter int QUEUE_DEPTH     = 32,
	parameter int MAX_FRAME_BYTES = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  rlftq_pkg::cmd_t                     cmd,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [15:0]                         cfg_data,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [rlftq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int FW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int STORE_DEPTH = QUEUE_DEPTH * MAX_FRAME_BYTES;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
	localparam logic [FW-1:0] MAX_FILL  = FW'(MAX_FRAME_BYTES);
	localparam logic [AW-1:0] SLOT_SPAN = AW'(MAX_FRAME_BYTES);

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	// Frame storage
	logic [7:0]    store_mem [STORE_DEPTH];
	logic [FW-1:0] len_mem   [QUEUE_DEPTH];
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [AW-1:0] st_raddr;
	logic [7:0]    st_rdata_q;
	logic          len_we;
	logic [FW-1:0] len_wdata;
	logic [SW-1:0] len_raddr;
	logic [FW-1:0] len_rdata_q;

	rlftq_pkg::back_state_t state_q, state_n;
	logic [SW-1:0] head_q, head_n;
	logic [SW-1:0] tail_q, tail_n;
	logic [CW-1:0] count_q, count_n;
	logic [FW-1:0] fill_q, fill_n;
	logic [1:0]    rej_q, rej_n;
	logic [31:0]   tick_q, tick_n;
	logic [31:0]   last_tick_q, last_tick_n;
	logic          first_q, first_n;
	logic [15:0]   interval_q;
	logic [FW-1:0] head_len_q, head_len_n;
	logic          rd_hit_q, rd_hit_n;
	rlftq_pkg::res_t out_q, out_n;
	logic          out_valid_q, out_valid_n;

	logic          out_free;
	logic          take;
	logic          pop_go;
	logic [31:0]   tick_inc;
	logic [FW-1:0] fill_v;
	logic [1:0]    rej_v;
	logic [FW-1:0] len_show;
	logic          rd_hit;

	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cmd_ready     = (state_q == rlftq_pkg::BK_IDLE) && out_free;
	assign take          = cmd_valid && cmd_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = rlftq_pkg::OUT_TDATA_W'(out_q);

	// A ready tick pops any head when the interval allows and the link is not busy
	assign tick_inc = tick_q + 32'd1;
	assign pop_go   = cmd.link_ready && (count_q != '0) &&
		(!first_q || ((tick_inc - last_tick_q) >= {16'd0, interval_q})) &&
		(cmd.link_status != rlftq_pkg::LINK_BUSY);

	assign st_raddr  = AW'(head_q) * SLOT_SPAN + AW'(cmd.byte_offset);
	assign st_waddr  = AW'(tail_q) * SLOT_SPAN + AW'(fill_q);
	assign len_raddr = next_slot(head_q);
	assign rd_hit    = (16'(cmd.byte_offset) < 16'(head_len_q)) && (count_q != '0) &&
		(16'(cmd.byte_offset) < 16'(MAX_FRAME_BYTES));

	always_comb begin
		state_n = state_q;
		case (state_q)
			rlftq_pkg::BK_IDLE: begin
				if (take && cmd.func == rlftq_pkg::FUNC_READ) begin
					state_n = rlftq_pkg::BK_READ;
				end else if (take && cmd.func == rlftq_pkg::FUNC_TICK && pop_go) begin
					state_n = rlftq_pkg::BK_LEN;
				end
			end
			rlftq_pkg::BK_LEN:  state_n = rlftq_pkg::BK_IDLE;
			rlftq_pkg::BK_READ: state_n = rlftq_pkg::BK_IDLE;
			default:            state_n = rlftq_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		fill_n      = fill_q;
		rej_n       = rej_q;
		tick_n      = tick_q;
		last_tick_n = last_tick_q;
		first_n     = first_q;
		head_len_n  = head_len_q;
		rd_hit_n    = rd_hit_q;
		out_n       = out_q;
		out_valid_n = out_valid_q && !m_axis_tready;
		st_we       = 1'b0;
		len_we      = 1'b0;
		len_wdata   = fill_q;
		fill_v      = fill_q;
		rej_v       = rej_q;
		len_show    = head_len_q;
		case (state_q)
			rlftq_pkg::BK_IDLE: begin
				if (take) begin
					out_n.status    = rlftq_pkg::ST_NONE;
					out_n.sent      = 1'b0;
					out_n.dropped   = 1'b0;
					out_n.read_data = 8'd0;
					case (cmd.func)
						rlftq_pkg::FUNC_PUSH: begin
							if (fill_q >= MAX_FILL) begin
								rej_v[rlftq_pkg::REJ_LONG] = 1'b1;
							end else begin
								if (count_q >= FULL_CNT) begin
									rej_v[rlftq_pkg::REJ_FULL] = 1'b1;
								end
								st_we  = (rej_v == 2'b00);
								fill_v = fill_q + 1'b1;
							end
							if (cmd.last_byte) begin
								if (rej_v[rlftq_pkg::REJ_LONG]) begin
									out_n.status = rlftq_pkg::ST_BAD_LEN;
								end else if (rej_v[rlftq_pkg::REJ_FULL]) begin
									out_n.status = rlftq_pkg::ST_FULL;
								end else begin
									out_n.status = rlftq_pkg::ST_OK;
									len_we       = 1'b1;
									len_wdata    = fill_v;
									tail_n       = next_slot(tail_q);
									count_n      = count_q + 1'b1;
									if (count_q == '0) begin
										head_len_n = fill_v;
									end
								end
								fill_n = '0;
								rej_n  = 2'b00;
							end else begin
								fill_n = fill_v;
								rej_n  = rej_v;
							end
							len_show           = head_len_n;
							out_n.frame_length = (count_n == '0) ? 8'd0 : 8'(len_show);
							out_n.queue_count  = 6'(count_n);
							out_valid_n        = 1'b1;
						end
						rlftq_pkg::FUNC_TICK: begin
							tick_n = tick_inc;
							if (pop_go) begin
								// Length of the new head arrives next cycle
								head_n        = next_slot(head_q);
								count_n       = count_q - 1'b1;
								last_tick_n   = tick_inc;
								first_n       = 1'b1;
								out_n.sent    = (cmd.link_status == rlftq_pkg::LINK_OK);
								out_n.dropped = (cmd.link_status != rlftq_pkg::LINK_OK);
								out_n.queue_count = 6'(count_n);
							end else begin
								out_n.frame_length = (count_q == '0) ? 8'd0 : 8'(head_len_q);
								out_n.queue_count  = 6'(count_q);
								out_valid_n        = 1'b1;
							end
						end
						rlftq_pkg::FUNC_READ: begin
							rd_hit_n           = rd_hit;
							out_n.frame_length = (count_q == '0) ? 8'd0 : 8'(head_len_q);
							out_n.queue_count  = 6'(count_q);
						end
						default: begin
							out_n.frame_length = (count_q == '0) ? 8'd0 : 8'(head_len_q);
							out_n.queue_count  = 6'(count_q);
							out_valid_n        = 1'b1;
						end
					endcase
				end
			end
			rlftq_pkg::BK_LEN: begin
				head_len_n         = len_rdata_q;
				out_n.frame_length = (count_q == '0) ? 8'd0 : 8'(len_rdata_q);
				out_valid_n        = 1'b1;
			end
			rlftq_pkg::BK_READ: begin
				out_n.read_data = rd_hit_q ? st_rdata_q : 8'd0;
				out_valid_n     = 1'b1;
			end
			default: begin
				out_valid_n = out_valid_q && !m_axis_tready;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= cmd.data_byte;
		end
		st_rdata_q <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[tail_q] <= len_wdata;
		end
		len_rdata_q <= len_mem[len_raddr];
	end

	always_ff @(posedge clk) begin
		out_q      <= out_n;
		head_len_q <= head_len_n;
		rd_hit_q   <= rd_hit_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlftq_pkg::BK_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			rej_q       <= 2'b00;
			tick_q      <= '0;
			last_tick_q <= '0;
			first_q     <= 1'b0;
			interval_q  <= rlftq_pkg::SEND_INTERVAL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			head_q      <= head_n;
			tail_q      <= tail_n;
			count_q     <= count_n;
			fill_q      <= fill_n;
			rej_q       <= rej_n;
			tick_q      <= tick_n;
			last_tick_q <= last_tick_n;
			first_q     <= first_n;
			out_valid_q <= out_valid_n;
			if (cfg_valid && cfg_ready) begin
				interval_q <= cfg_data;
			end
		end
	end

endmodule

// ===== src/rate_limited_frame_tx_queue_core.sv =====
// Transmit queue of QUEUE_DEPTH frame slots of up to MAX_FRAME_BYTES bytes each, with a
// minimum spacing of send_interval ticks between link sends after the first. Every input
// transfer gives exactly one output transfer, in order. Items pass through a two-entry
// command queue into the execution unit; a push, a no-op and a tick that pops nothing are
// done in BK_IDLE; a read or a popping tick also passes BK_READ or BK_LEN, as the frame
// byte or next head length comes from a memory with a registered read port. A new item
// is taken in BK_IDLE if the output register is empty or being drained. The frame store
// and the length table need no clearing after reset: only written entries are ever read.
module rate_limited_frame_tx_queue_core #(
	parameter int QUEUE_DEPTH     = 32,
	parameter int MAX_FRAME_BYTES = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// data_byte[7:0], link_ready[8], link_status[10:9], byte_offset[17:11], zero fill
	input  logic [rlftq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic                                s_axis_tlast,
	// func[1:0]
	input  logic [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status[1:0], sent[2], dropped[3], frame_length[11:4], read_data[19:12],
	// queue_count[25:20], zero fill
	output logic [rlftq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [15:0]                         cfg_data
);

	logic            cmd_valid;
	logic            cmd_ready;
	rlftq_pkg::cmd_t cmd;

	rlftq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	rlftq_back #(
		.QUEUE_DEPTH     (QUEUE_DEPTH),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== dv/tb_rate_limited_frame_tx_queue_core.sv =====
`timescale 1ns / 1ps

module tb_rate_limited_frame_tx_queue_core;
	import rlftq_pkg::*;

	localparam int QD   = 32;
	localparam int MAXB = 128;

	localparam logic [1:0] LINK_ERR = 2'd2;
	localparam logic [1:0] LINK_BAD = 2'd3;

	localparam int MODE_MIX   = 0;
	localparam int MODE_FILL  = 1;
	localparam int MODE_DRAIN = 2;

	localparam int RX_HOLD_CYCLES = 400;
	localparam int TIMEOUT_NS     = 2_000_000;

	typedef struct {
		func_t       fn;
		logic [7:0]  dat;
		logic        lst;
		logic        rdy;
		logic [1:0]  lstat;
		logic [6:0]  off;
		int          reps;
		bit          each;
		bit          typed;
		res_t        want;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tlast;
	logic [1:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [15:0]            cfg_data;

	rate_limited_frame_tx_queue_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the queue
	logic [7:0]  slot_bytes [QD][MAXB];
	logic [7:0]  slot_len [QD];
	logic [4:0]  head_ix;
	logic [4:0]  tail_ix;
	int unsigned n_waiting;
	int unsigned fill_pos;
	logic [1:0]  reject_why;
	logic [31:0] tick_now;
	logic [31:0] tick_last_pop;
	bit          popped_once;
	logic [15:0] send_gap;

	res_t replies_due [$];
	int   n_bad_replies = 0;
	int   n_items = 0;
	int   n_queued = 0, n_full = 0, n_too_long = 0, n_sent = 0, n_drop = 0, n_reads = 0;
	bit   quiet = 1'b0;
	bit   hold_req = 1'b0;

	function automatic int unsigned head_len_now();
		return (n_waiting == 0) ? 0 : int'(slot_len[head_ix]);
	endfunction

	function automatic res_t res_of(status_t st, bit snt, bit drp, int len, int rd, int cnt);
		res_t r;
		r.status       = st;
		r.sent         = snt;
		r.dropped      = drp;
		r.frame_length = 8'(len);
		r.read_data    = 8'(rd);
		r.queue_count  = 6'(cnt);
		return r;
	endfunction

	// Apply one item to the shadow queue and return the reply it should produce
	function automatic res_t step_tx_queue(cmd_t c);
		res_t        r;
		logic [31:0] since;
		r        = '0;
		r.status = ST_NONE;
		case (c.func)
			FUNC_PUSH: begin
				if (fill_pos >= MAXB) begin
					reject_why[REJ_LONG] = 1'b1;
				end else begin
					if (n_waiting >= QD)
						reject_why[REJ_FULL] = 1'b1;
					if (reject_why == 2'b00)
						slot_bytes[tail_ix][fill_pos] = c.data_byte;
					fill_pos++;
				end
				if (c.last_byte) begin
					if (reject_why[REJ_LONG]) begin
						r.status = ST_BAD_LEN;
					end else if (reject_why[REJ_FULL]) begin
						r.status = ST_FULL;
					end else begin
						slot_len[tail_ix] = 8'(fill_pos);
						tail_ix = tail_ix + 5'd1;
						n_waiting++;
						r.status = ST_OK;
					end
					fill_pos   = 0;
					reject_why = 2'b00;
				end
			end
			FUNC_TICK: begin
				tick_now = tick_now + 32'd1;
				since    = tick_now - tick_last_pop;
				if (c.link_ready && n_waiting > 0 && (!popped_once || since >= {16'd0, send_gap})
						&& c.link_status != LINK_BUSY) begin
					head_ix = head_ix + 5'd1;
					n_waiting--;
					tick_last_pop = tick_now;
					popped_once   = 1'b1;
					if (c.link_status == LINK_OK)
						r.sent = 1'b1;
					else
						r.dropped = 1'b1;
				end
			end
			FUNC_READ: begin
				if (c.byte_offset < head_len_now())
					r.read_data = slot_bytes[head_ix][c.byte_offset];
			end
			default: ;
		endcase
		r.frame_length = 8'(head_len_now());
		r.queue_count  = 6'(n_waiting);
		return r;
	endfunction

	// Offer one item; returns at the edge where it is taken
	task automatic send_item(cmd_t c, bit typed, res_t want);
		res_t r;
		int   gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, c.byte_offset, c.link_status, c.link_ready, c.data_byte};
		s_axis_tlast  <= c.last_byte;
		s_axis_tuser  <= c.func;
		r = step_tx_queue(c);
		replies_due.push_back(typed ? want : r);
		n_items++;
		case (r.status)
			ST_OK:      n_queued++;
			ST_FULL:    n_full++;
			ST_BAD_LEN: n_too_long++;
			default: ;
		endcase
		n_sent += r.sent;
		n_drop += r.dropped;
		if (c.func == FUNC_READ)
			n_reads++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_replies();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(negedge clk);
	endtask

	task automatic set_interval(logic [15:0] v);
		drain_replies();
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		send_gap = v;
	endtask

	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.func        = func_t'($urandom_range(0, 3));
		c.data_byte   = 8'($urandom);
		c.last_byte   = 1'($urandom);
		c.link_ready  = 1'($urandom);
		c.link_status = 2'($urandom);
		c.byte_offset = 7'($urandom);
		return c;
	endfunction

	function automatic cmd_t tick_cmd();
		cmd_t c;
		int   p;
		c            = noise_cmd();
		c.func       = FUNC_TICK;
		c.link_ready = ($urandom_range(0, 9) < 8);
		p            = $urandom_range(0, 99);
		if (p < 70)
			c.link_status = LINK_OK;
		else if (p < 82)
			c.link_status = LINK_BUSY;
		else if (p < 94)
			c.link_status = LINK_ERR;
		else
			c.link_status = LINK_BAD;
		return c;
	endfunction

	function automatic cmd_t read_cmd();
		cmd_t        c;
		int unsigned hl;
		c      = noise_cmd();
		c.func = FUNC_READ;
		hl     = head_len_now();
		if (hl > 0 && $urandom_range(0, 99) < 75)
			c.byte_offset = 7'($urandom_range(0, hl - 1));
		return c;
	endfunction

	function automatic int frame_len(int mode);
		int p;
		p = $urandom_range(0, 99);
		if (mode == MODE_FILL && p < 90)
			return $urandom_range(1, 3);
		if (p < 85)
			return $urandom_range(1, 16);
		if (p < 95)
			return $urandom_range(17, MAXB);
		return $urandom_range(MAXB + 1, MAXB + 8);
	endfunction

	// Push a whole frame, now and then slipping a tick or a read between its bytes
	task automatic push_frame(int len);
		cmd_t c;
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 99) < 12)
				send_item(($urandom_range(0, 1) != 0) ? tick_cmd() : read_cmd(), 1'b0, '0);
			c           = noise_cmd();
			c.func      = FUNC_PUSH;
			c.last_byte = (i == len - 1);
			send_item(c, 1'b0, '0);
		end
	endtask

	task automatic run_items(int count, int mode);
		int   stop_at;
		int   p;
		int   w_frame;
		int   w_tick;
		int   w_read;
		cmd_t c;
		stop_at = n_items + count;
		case (mode)
			MODE_FILL:  begin w_frame = 70; w_tick = 10; w_read = 15; end
			MODE_DRAIN: begin w_frame = 25; w_tick = 50; w_read = 20; end
			default:    begin w_frame = 40; w_tick = 35; w_read = 20; end
		endcase
		while (n_items < stop_at) begin
			if ($urandom_range(0, 63) == 0)
				quiet = !quiet;
			p = $urandom_range(0, 99);
			if (p < w_frame) begin
				push_frame(frame_len(mode));
			end else if (p < w_frame + w_tick) begin
				send_item(tick_cmd(), 1'b0, '0);
			end else if (p < w_frame + w_tick + w_read) begin
				send_item(read_cmd(), 1'b0, '0);
			end else begin
				c      = noise_cmd();
				c.func = FUNC_NOP;
				send_item(c, 1'b0, '0);
			end
		end
	endtask

	task automatic report_reply(string what, res_t want, res_t got);
		if (n_bad_replies < 10)
			$display("%t %s: want st=%0d snt=%0d drp=%0d len=%0d rd=%02h cnt=%0d, got st=%0d snt=%0d drp=%0d len=%0d rd=%02h cnt=%0d",
				$realtime, what, want.status, want.sent, want.dropped, want.frame_length,
				want.read_data, want.queue_count, got.status, got.sent, got.dropped,
				got.frame_length, got.read_data, got.queue_count);
		n_bad_replies++;
	endtask

	always @(posedge clk) begin : reply_check
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[25:0]);
			if (replies_due.size() == 0) begin
				report_reply("unexpected reply", '0, got);
			end else begin
				want = replies_due.pop_front();
				if (got !== want)
					report_reply("reply mismatch", want, got);
			end
		end
	end

	initial begin : rx_side
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			@(negedge clk);
			if (hold_req) begin
				gap = RX_HOLD_CYCLES;
				hold_req <= 1'b0;
			end else begin
				gap = quiet ? 0 : $urandom_range(0, 7);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d replies outstanding", replies_due.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : main
		dir_row_t steps_tab [26];
		cmd_t     c;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		s_axis_tuser  = FUNC_NOP;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		head_ix       = '0;
		tail_ix       = '0;
		n_waiting     = 0;
		fill_pos      = 0;
		reject_why    = 2'b00;
		tick_now      = '0;
		tick_last_pop = '0;
		popped_once   = 1'b0;
		send_gap      = SEND_INTERVAL_RESET;

		// Directed part runs with the reset interval of 115 ticks
		steps_tab = '{
			'{FUNC_NOP,  8'h00, 1'b0, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 0, 0, 0)},
			'{FUNC_READ, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 0, 0, 0)},
			'{FUNC_READ, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd127, 1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 0, 0, 0)},
			// tick on an empty queue sends nothing
			'{FUNC_TICK, 8'h00, 1'b0, 1'b1, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 0, 0, 0)},
			'{FUNC_PUSH, 8'hFF, 1'b1, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_OK, 0, 0, 1, 0, 1)},
			'{FUNC_READ, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 1, 8'hFF, 1)},
			// offset equal to the frame length reads zero
			'{FUNC_READ, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd1,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 1, 0, 1)},
			'{FUNC_PUSH, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b0, '0},
			'{FUNC_PUSH, 8'hA5, 1'b1, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_OK, 0, 0, 1, 0, 2)},
			'{FUNC_TICK, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 1, 0, 2)},
			// busy link keeps the frame
			'{FUNC_TICK, 8'h00, 1'b0, 1'b1, LINK_BUSY, 7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 1, 0, 2)},
			// first send goes out at once
			'{FUNC_TICK, 8'h00, 1'b0, 1'b1, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 1, 0, 2, 0, 1)},
			'{FUNC_TICK, 8'h00, 1'b0, 1'b1, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 2, 0, 1)},
			'{FUNC_READ, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd1,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 2, 8'hA5, 1)},
			// one byte too many
			'{FUNC_PUSH, 8'h10, 1'b1, 1'b0, LINK_OK,   7'd0,   129, 1'b0, 1'b1,
				res_of(ST_BAD_LEN, 0, 0, 2, 0, 1)},
			'{FUNC_PUSH, 8'h80, 1'b1, 1'b0, LINK_OK,   7'd0,   128, 1'b0, 1'b1,
				res_of(ST_OK, 0, 0, 2, 0, 2)},
			'{FUNC_PUSH, 8'h33, 1'b1, 1'b0, LINK_OK,   7'd0,   30,  1'b1, 1'b1,
				res_of(ST_OK, 0, 0, 2, 0, 32)},
			'{FUNC_PUSH, 8'h44, 1'b1, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_FULL, 0, 0, 2, 0, 32)},
			// frame starts while full, a slot frees before its last byte
			'{FUNC_PUSH, 8'h55, 1'b0, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b0, '0},
			'{FUNC_TICK, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd0,   115, 1'b0, 1'b0, '0},
			'{FUNC_TICK, 8'h00, 1'b0, 1'b1, LINK_ERR,  7'd0,   1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 1, 128, 0, 31)},
			'{FUNC_PUSH, 8'h66, 1'b1, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b1,
				res_of(ST_FULL, 0, 0, 128, 0, 31)},
			'{FUNC_READ, 8'h00, 1'b0, 1'b0, LINK_OK,   7'd127, 1,   1'b0, 1'b1,
				res_of(ST_NONE, 0, 0, 128, 8'hFF, 31)},
			// unknown link status drops once the interval has passed
			'{FUNC_TICK, 8'h00, 1'b0, 1'b1, LINK_BAD,  7'd0,   115, 1'b0, 1'b1,
				res_of(ST_NONE, 0, 1, 1, 0, 30)},
			'{FUNC_PUSH, 8'h77, 1'b1, 1'b0, LINK_OK,   7'd0,   1,   1'b0, 1'b0, '0},
			'{FUNC_TICK, 8'h00, 1'b0, 1'b1, LINK_OK,   7'd0,   1,   1'b0, 1'b0, '0}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (steps_tab[i]) begin
			for (int k = 0; k < steps_tab[i].reps; k++) begin
				c.func        = steps_tab[i].fn;
				c.data_byte   = steps_tab[i].dat + 8'(k);
				c.last_byte   = (steps_tab[i].each || k == steps_tab[i].reps - 1) ?
					steps_tab[i].lst : 1'b0;
				c.link_ready  = steps_tab[i].rdy;
				c.link_status = steps_tab[i].lstat;
				c.byte_offset = steps_tab[i].off;
				send_item(c, steps_tab[i].typed && k == steps_tab[i].reps - 1,
					steps_tab[i].want);
			end
		end

		set_interval(16'd0);
		// stall the reply side for a long stretch while items keep coming
		hold_req <= 1'b1;
		run_items(350, MODE_MIX);
		set_interval(16'd3);
		run_items(300, MODE_MIX);
		set_interval(16'hFFFF);
		run_items(200, MODE_FILL);
		set_interval(16'd1);
		run_items(250, MODE_DRAIN);

		drain_replies();
		repeat (20) @(posedge clk);

		$display("Ran %0d items: %0d frames queued, %0d refused as full, %0d refused as too long",
			n_items, n_queued, n_full, n_too_long);
		$display("Link saw %0d sends and %0d drops, %0d reads; %0d bad replies",
			n_sent, n_drop, n_reads, n_bad_replies);
		if (n_bad_replies == 0 && replies_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rlftq_pkg.sv
src/rlftq_front.sv
src/rlftq_back.sv
src/rate_limited_frame_tx_queue_core.sv
dv/tb_rate_limited_frame_tx_queue_core.sv
